// ===== hdl/fmr_pkg.sv =====
// Shared types and constants for the framed message receiver.
// Used by fmr_ctrl, fmr_datapath and framed_message_receiver; no dependencies.
package fmr_pkg;

    localparam int LEN_W = 7;
    localparam int IDX_W = 7;

    localparam logic [7:0] START_MARK = 8'h02;
    localparam logic [7:0] NACK_MARK  = 8'h02;
    localparam logic [7:0] NACK_CODE  = 8'h4E;
    localparam logic [7:0] NACK_SUM   = 8'hB0;
    localparam logic [IDX_W-1:0] NACK_LAST = 7'd3;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 7'd64;

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_MSG  = 2'd1,
        KIND_NACK = 2'd2,
        KIND_DROP = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_BODY,
        ST_NACK,
        ST_MSG_RD,
        ST_MSG_OUT
    } t_state;

    typedef enum logic [2:0] {
        OSEL_NONE,
        OSEL_TEXT,
        OSEL_DROP,
        OSEL_NACK,
        OSEL_MSG
    } t_out_sel;

    typedef struct packed {
        logic     sum_clear;
        logic     len_load;
        logic     body_write;
        logic     idx_clear;
        logic     idx_inc;
        logic     rd_en;
        t_out_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic is_start;
        logic len_bad;
        logic body_done;
        logic sum_ok;
        logic len_one;
        logic nack_done;
        logic msg_last;
        logic out_free;
    } t_status;

    function automatic logic [7:0] nack_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = NACK_MARK;
            2'd1:    b = NACK_MARK;
            2'd2:    b = NACK_CODE;
            default: b = NACK_SUM;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/framed_message_receiver.sv =====
// Framed message receiver top level: controller plus datapath.
// Depends on fmr_pkg, fmr_ctrl and fmr_datapath.
//
//   channel   direction   handshake            payload
//   input     in          i_valid / o_stall    i_rx_byte
//   result    out         o_valid / i_stall    o_out_kind, o_out_byte, o_out_last
//   config    in          i_cfg_wr_en          i_cfg_wr_data (max_frame_len)
//
// Requests (text, start mark, length and body bytes) are taken in the idle, length and
// body phases, whenever the output register is empty or being drained.
// A NACK is sent byte by byte from the NACK table; an accepted message is sent byte
// by byte via the frame buffer's registered read port (address, then output step).
// Reset (synchronous, active low) returns to idle, empties the output register and
// sets max_frame_len to 64. The frame buffer is not cleared.
// A stalled result holds the output register; new requests wait behind it.
module framed_message_receiver
    import fmr_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_rx_byte,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    t_cmd    cmd;
    t_status sts;

    fmr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fmr_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_kind    (o_out_kind),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last)
    );

endmodule

// ===== hdl/fmr_ctrl.sv =====
// Frame receiver controller: phase state machine issuing datapath commands.
// Depends on fmr_pkg for the state, command and status types.
module fmr_ctrl
    import fmr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   ready;
    logic   accept;

    assign ready  = ((r_state == ST_IDLE) || (r_state == ST_LEN) || (r_state == ST_BODY))
                    && i_sts.out_free;
    assign accept = i_valid && ready;
    assign o_stall = !ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_sts.is_start) begin
                    n_state = ST_LEN;
                end
            end
            ST_LEN: begin
                if (accept) begin
                    n_state = i_sts.len_bad ? ST_IDLE : ST_BODY;
                end
            end
            ST_BODY: begin
                if (accept && i_sts.body_done) begin
                    if (!i_sts.sum_ok) begin
                        n_state = ST_NACK;
                    end else if (i_sts.len_one) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MSG_RD;
                    end
                end
            end
            ST_NACK: begin
                if (i_sts.out_free && i_sts.nack_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MSG_RD: begin
                n_state = ST_MSG_OUT;
            end
            ST_MSG_OUT: begin
                if (i_sts.out_free) begin
                    n_state = i_sts.msg_last ? ST_IDLE : ST_MSG_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '{sum_clear: 1'b0, len_load: 1'b0, body_write: 1'b0, idx_clear: 1'b0,
                  idx_inc: 1'b0, rd_en: 1'b0, out_sel: OSEL_NONE};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_sts.is_start) begin
                        o_cmd.sum_clear = 1'b1;
                    end else begin
                        o_cmd.out_sel = OSEL_TEXT;
                    end
                end
            end
            ST_LEN: begin
                if (accept) begin
                    if (i_sts.len_bad) begin
                        o_cmd.out_sel = OSEL_DROP;
                    end else begin
                        o_cmd.len_load = 1'b1;
                    end
                end
            end
            ST_BODY: begin
                if (accept) begin
                    o_cmd.body_write = 1'b1;
                    o_cmd.idx_clear  = i_sts.body_done;
                end
            end
            ST_NACK: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = OSEL_NACK;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            ST_MSG_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_MSG_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_sel = OSEL_MSG;
                    o_cmd.idx_inc = 1'b1;
                end
            end
            default: begin
                o_cmd.out_sel = OSEL_NONE;
            end
        endcase
    end

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_sel != OSEL_NONE) |-> i_sts.out_free)
        else $error("result loaded while output register busy");

    a_read_before_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MSG_OUT) |-> ($past(r_state) == ST_MSG_RD || $past(r_state) == ST_MSG_OUT))
        else $error("message byte emitted without a preceding read");

    a_no_accept_while_emitting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NACK || r_state == ST_MSG_RD || r_state == ST_MSG_OUT) |-> o_stall)
        else $error("request accepted during emission");

endmodule

// ===== hdl/fmr_datapath.sv =====
// Frame receiver datapath: sum, counters, frame buffer and output register.
// Depends on fmr_pkg for command/status types, constants and the NACK table.
module fmr_datapath
    import fmr_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [LEN_W-1:0] i_cfg_wr_data,
    input  logic [7:0]       i_rx_byte,
    input  t_cmd             i_cmd,
    output t_status          o_sts,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_out_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last
);

    localparam int AW  = $clog2(FRAME_DEPTH);
    localparam int CAP = (FRAME_DEPTH < 127) ? FRAME_DEPTH : 127;

    logic [LEN_W-1:0] r_max_len;
    logic [7:0]       r_sum;
    logic [LEN_W-1:0] r_count;
    logic [LEN_W-1:0] r_len;
    logic [IDX_W-1:0] r_idx;
    logic [7:0]       r_rd_data;
    logic [7:0]       r_mem [FRAME_DEPTH];

    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [7:0]       r_out_byte;
    logic             r_out_last;

    logic [LEN_W-1:0] limit;
    logic [7:0]       sum_next;
    logic [7:0]       count_next;
    logic             out_free;

    assign limit      = (r_max_len < LEN_W'(CAP)) ? r_max_len : LEN_W'(CAP);
    assign sum_next   = r_sum + i_rx_byte;
    assign count_next = {1'b0, r_count} + 8'd1;
    assign out_free   = !r_out_valid || !i_stall;

    assign o_sts.is_start  = (i_rx_byte == START_MARK);
    assign o_sts.len_bad   = (i_rx_byte == 8'd0) || (i_rx_byte > {1'b0, limit});
    assign o_sts.body_done = (count_next >= {1'b0, r_len});
    assign o_sts.sum_ok    = (sum_next == 8'd0);
    assign o_sts.len_one   = (r_len == 7'd1);
    assign o_sts.nack_done = (r_idx == NACK_LAST);
    assign o_sts.msg_last  = (({1'b0, r_idx} + 8'd2) == {1'b0, r_len});
    assign o_sts.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_len   <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.sum_clear) begin
                r_sum <= '0;
            end else if (i_cmd.len_load || i_cmd.body_write) begin
                r_sum <= sum_next;
            end
            if (i_cmd.len_load) begin
                r_len   <= i_rx_byte[LEN_W-1:0];
                r_count <= '0;
            end else if (i_cmd.body_write) begin
                r_count <= count_next[LEN_W-1:0];
            end
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 7'd1;
            end
        end
    end

    // frame buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.body_write) begin
            r_mem[AW'(r_count)] <= i_rx_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[AW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_sel != OSEL_NONE) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.out_sel)
            OSEL_TEXT: begin
                r_out_kind <= KIND_TEXT;
                r_out_byte <= i_rx_byte;
                r_out_last <= 1'b1;
            end
            OSEL_DROP: begin
                r_out_kind <= KIND_DROP;
                r_out_byte <= i_rx_byte;
                r_out_last <= 1'b1;
            end
            OSEL_NACK: begin
                r_out_kind <= KIND_NACK;
                r_out_byte <= nack_byte(r_idx[1:0]);
                r_out_last <= o_sts.nack_done;
            end
            OSEL_MSG: begin
                r_out_kind <= KIND_MSG;
                r_out_byte <= r_rd_data;
                r_out_last <= o_sts.msg_last;
            end
            default: begin
                r_out_kind <= r_out_kind;
            end
        endcase
    end

    assign o_valid    = r_out_valid;
    assign o_out_kind = r_out_kind;
    assign o_out_byte = r_out_byte;
    assign o_out_last = r_out_last;

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_sel != OSEL_NONE) |=> r_out_valid)
        else $error("loaded result not presented");

    a_write_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.body_write |-> (r_count < r_len))
        else $error("frame buffer write past frame length");

    a_read_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (({1'b0, r_idx} + 8'd2) <= {1'b0, r_len}))
        else $error("frame buffer read past message end");

endmodule
